/* hw/rtl/bpc_pkg.sv */
`default_nettype none
package bpc_pkg;

    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 16;
    localparam int unsigned TimeW = 16;
    localparam int unsigned UptimeW = 15;
    localparam int unsigned MaxResults = 3;
    localparam int unsigned QueueDepth = 4;

    // register indexes of the config port
    localparam logic [CfgIdxW-1:0] CfgOnLevel = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgInvertState = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgResetDetectEnable = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgShortPressMs = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgLongPressMs = 3'd4;

    // press machine states
    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StWaitOffSingle = 3'd1;
    localparam logic [2:0] StWaitOnDouble = 3'd2;
    localparam logic [2:0] StWaitOffDouble = 3'd3;
    localparam logic [2:0] StWaitOffLong = 3'd4;

    // event codes
    localparam logic [2:0] EvChange = 3'd0;
    localparam logic [2:0] EvReset = 3'd1;
    localparam logic [2:0] EvSingle = 3'd2;
    localparam logic [2:0] EvDouble = 3'd3;
    localparam logic [2:0] EvLong = 3'd4;

    // request kinds
    localparam logic FuncTick = 1'b0;
    localparam logic FuncPinChange = 1'b1;

    localparam logic [TimeW-1:0] ShortPressReset = 16'd500;
    localparam logic [TimeW-1:0] LongPressReset = 16'd1000;

    localparam logic [UptimeW-1:0] UptimeLimitMs = 15'd30000;
    localparam logic [UptimeW-1:0] GapLimitMs = 15'd5000;
    localparam logic [3:0] TogglesForReset = 4'd10;

    typedef struct packed {
        logic             on_level;
        logic             invert_state;
        logic             reset_detect_enable;
        logic [TimeW-1:0] short_press_ms;
        logic [TimeW-1:0] long_press_ms;
    } t_cfg;

    typedef struct packed {
        logic               prev_logical;
        logic [2:0]         press_state;
        logic [TimeW-1:0]   timer_remaining;
        logic               timer_armed;
        logic [1:0]         expiry_count;
        logic [UptimeW-1:0] uptime_ms;
        logic [UptimeW-1:0] last_change_ms;
        logic [3:0]         toggle_count;
    } t_state;

    typedef struct packed {
        logic [2:0] event_code;
        logic       logical_level;
        logic       last_of_run;
    } t_result;

endpackage
`default_nettype wire

/* hw/rtl/bpc_in_if.sv */
`default_nettype none
interface bpc_in_if;
    logic valid;
    logic ready;
    logic func;
    logic pin_level;

    modport source (output valid, output func, output pin_level, input ready);
    modport sink (input valid, input func, input pin_level, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bpc_out_if.sv */
`default_nettype none
interface bpc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_code;
    logic       logical_level;
    logic       last_of_run;

    modport source (output valid, output event_code, output logical_level,
                    output last_of_run, input ready);
    modport sink (input valid, input event_code, input logical_level,
                  input last_of_run, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bpc_step.sv */
`default_nettype none
module bpc_step (
    input  wire bpc_pkg::t_cfg    i_cfg,
    input  wire bpc_pkg::t_state  i_state,
    input  wire logic             i_func,
    input  wire logic             i_pin_level,
    output bpc_pkg::t_state       o_state,
    output bpc_pkg::t_result      o_res [bpc_pkg::MaxResults],
    output logic [1:0]            o_res_count
);

    always_comb begin
        bpc_pkg::t_state  st;
        bpc_pkg::t_result res [bpc_pkg::MaxResults];
        logic [1:0]       cnt;
        logic             cur;
        logic             last;

        st = i_state;
        cnt = 2'd0;
        for (int k = 0; k < bpc_pkg::MaxResults; k++) begin
            res[k] = '0;
        end
        cur = (i_pin_level == i_cfg.on_level) ^ i_cfg.invert_state;
        last = i_state.prev_logical;

        if (i_func == bpc_pkg::FuncTick) begin
            if (st.uptime_ms < bpc_pkg::UptimeLimitMs) begin
                st.uptime_ms = st.uptime_ms + 15'd1;
            end
            if (st.timer_armed) begin
                if (st.timer_remaining != '0) begin
                    st.timer_remaining = st.timer_remaining - 16'd1;
                end
                if (st.timer_remaining == '0) begin
                    st.timer_armed = 1'b0;
                    if (st.expiry_count != 2'd3) begin
                        st.expiry_count = st.expiry_count + 2'd1;
                    end
                    st.prev_logical = cur;
                    unique case (st.press_state)
                        bpc_pkg::StWaitOffSingle, bpc_pkg::StWaitOffDouble: begin
                            // second phase runs for the rest of the long hold
                            if (i_cfg.long_press_ms > i_cfg.short_press_ms) begin
                                st.timer_remaining = i_cfg.long_press_ms
                                                   - i_cfg.short_press_ms;
                            end else begin
                                st.timer_remaining = 16'd1;
                            end
                            st.timer_armed = 1'b1;
                            st.press_state = bpc_pkg::StWaitOffLong;
                        end
                        bpc_pkg::StWaitOnDouble: begin
                            res[cnt] = '{event_code: bpc_pkg::EvSingle, logical_level: cur,
                                         last_of_run: 1'b0};
                            cnt = cnt + 2'd1;
                            st.press_state = bpc_pkg::StIdle;
                        end
                        bpc_pkg::StWaitOffLong: begin
                            if (st.expiry_count == 2'd2) begin
                                res[cnt] = '{event_code: bpc_pkg::EvLong,
                                             logical_level: cur, last_of_run: 1'b0};
                                cnt = cnt + 2'd1;
                            end
                        end
                        default: begin
                            st.press_state = bpc_pkg::StIdle;
                        end
                    endcase
                end
            end
        end else begin
            st.prev_logical = cur;
            if (cur != last) begin
                res[cnt] = '{event_code: bpc_pkg::EvChange, logical_level: cur,
                             last_of_run: 1'b0};
                cnt = cnt + 2'd1;
                if (i_cfg.reset_detect_enable
                        && (st.uptime_ms < bpc_pkg::UptimeLimitMs)) begin
                    // uptime never falls below the last change stamp
                    if ((st.uptime_ms - st.last_change_ms) > bpc_pkg::GapLimitMs) begin
                        st.toggle_count = 4'd0;
                    end
                    st.toggle_count = st.toggle_count + 4'd1;
                    if (st.toggle_count >= bpc_pkg::TogglesForReset) begin
                        st.toggle_count = 4'd0;
                        res[cnt] = '{event_code: bpc_pkg::EvReset, logical_level: cur,
                                     last_of_run: 1'b0};
                        cnt = cnt + 2'd1;
                    end
                end
                unique case (st.press_state)
                    bpc_pkg::StWaitOffSingle: begin
                        if (!cur) begin
                            st.press_state = bpc_pkg::StWaitOnDouble;
                        end
                    end
                    bpc_pkg::StWaitOnDouble: begin
                        if (cur) begin
                            st.timer_remaining = (i_cfg.short_press_ms == '0)
                                               ? 16'd1 : i_cfg.short_press_ms;
                            st.timer_armed = 1'b1;
                            st.press_state = bpc_pkg::StWaitOffDouble;
                            st.expiry_count = 2'd0;
                        end
                    end
                    bpc_pkg::StWaitOffDouble: begin
                        if (!cur) begin
                            st.timer_armed = 1'b0;
                            st.timer_remaining = '0;
                            res[cnt] = '{event_code: bpc_pkg::EvDouble, logical_level: cur,
                                         last_of_run: 1'b0};
                            cnt = cnt + 2'd1;
                            st.press_state = bpc_pkg::StIdle;
                        end
                    end
                    bpc_pkg::StWaitOffLong: begin
                        if (!cur) begin
                            st.timer_armed = 1'b0;
                            st.timer_remaining = '0;
                            if (st.expiry_count == 2'd1) begin
                                res[cnt] = '{event_code: bpc_pkg::EvSingle,
                                             logical_level: cur, last_of_run: 1'b0};
                                cnt = cnt + 2'd1;
                            end
                            st.press_state = bpc_pkg::StIdle;
                        end
                    end
                    default: begin
                        st.press_state = bpc_pkg::StIdle;
                        if (cur) begin
                            st.timer_remaining = (i_cfg.short_press_ms == '0)
                                               ? 16'd1 : i_cfg.short_press_ms;
                            st.timer_armed = 1'b1;
                            st.press_state = bpc_pkg::StWaitOffSingle;
                            st.expiry_count = 2'd0;
                        end
                    end
                endcase
                st.last_change_ms = st.uptime_ms;
            end
        end

        for (int k = 0; k < bpc_pkg::MaxResults; k++) begin
            res[k].last_of_run = (2'(k + 1) == cnt);
        end

        o_state = st;
        o_res = res;
        o_res_count = cnt;
    end

endmodule
`default_nettype wire

/* hw/rtl/button_press_classifier_core.sv */
// order: the results of an accepted request are registered into the result queue and are
//   offered from its head in order, one per cycle while the receiver is ready
// throughput: one request per cycle, set by the four-entry result queue, which takes a
//   request while it holds at most one result
// reset: synchronous, active low; clears the classifier state, loads the register defaults
//   and empties the result queue, with no clearing pass
`default_nettype none
module button_press_classifier_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    bpc_in_if.sink                             i_in_ch,
    bpc_out_if.source                          o_out_ch,
    input  wire logic                          i_cfg_we,
    input  wire logic [bpc_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  wire logic [bpc_pkg::CfgDataW-1:0]  i_cfg_data
);

    bpc_pkg::t_cfg    r_cfg;
    bpc_pkg::t_state  r_state;
    bpc_pkg::t_state  n_state;
    bpc_pkg::t_result r_q [bpc_pkg::QueueDepth];
    bpc_pkg::t_result n_q [bpc_pkg::QueueDepth];
    logic [2:0]       r_count;
    logic [2:0]       n_count;

    bpc_pkg::t_state  step_state;
    bpc_pkg::t_result step_res [bpc_pkg::MaxResults];
    logic [1:0]       step_count;

    logic push;
    logic pop;

    bpc_step u_step (
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .i_func      (i_in_ch.func),
        .i_pin_level (i_in_ch.pin_level),
        .o_state     (step_state),
        .o_res       (step_res),
        .o_res_count (step_count)
    );

    // room for a full burst of results even if nothing drains this cycle
    assign i_in_ch.ready = (r_count <= 3'(bpc_pkg::QueueDepth - bpc_pkg::MaxResults));
    assign push = i_in_ch.valid && i_in_ch.ready;
    assign pop = (r_count != 3'd0) && o_out_ch.ready;

    assign o_out_ch.valid = (r_count != 3'd0);
    assign o_out_ch.event_code = r_q[0].event_code;
    assign o_out_ch.logical_level = r_q[0].logical_level;
    assign o_out_ch.last_of_run = r_q[0].last_of_run;

    assign n_state = push ? step_state : r_state;

    always_comb begin
        bpc_pkg::t_result sh [bpc_pkg::QueueDepth];
        logic [2:0]       base;
        logic [2:0]       nadd;
        logic [2:0]       k;

        base = r_count - {2'd0, pop};
        nadd = push ? {1'b0, step_count} : 3'd0;
        for (int i = 0; i < bpc_pkg::QueueDepth - 1; i++) begin
            sh[i] = pop ? r_q[i + 1] : r_q[i];
        end
        sh[bpc_pkg::QueueDepth - 1] = r_q[bpc_pkg::QueueDepth - 1];
        for (int i = 0; i < bpc_pkg::QueueDepth; i++) begin
            k = 3'(i) - base;
            n_q[i] = sh[i];
            if ((3'(i) >= base) && (k < nadd)) begin
                n_q[i] = step_res[k[1:0]];
            end
        end
        n_count = base + nadd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{on_level: 1'b1, invert_state: 1'b0, reset_detect_enable: 1'b0,
                       short_press_ms: bpc_pkg::ShortPressReset,
                       long_press_ms: bpc_pkg::LongPressReset};
            r_state <= '0;
            r_count <= 3'd0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    bpc_pkg::CfgOnLevel:           r_cfg.on_level <= i_cfg_data[0];
                    bpc_pkg::CfgInvertState:       r_cfg.invert_state <= i_cfg_data[0];
                    bpc_pkg::CfgResetDetectEnable: r_cfg.reset_detect_enable <= i_cfg_data[0];
                    bpc_pkg::CfgShortPressMs:      r_cfg.short_press_ms <= i_cfg_data;
                    bpc_pkg::CfgLongPressMs:       r_cfg.long_press_ms <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'(bpc_pkg::QueueDepth))
        else $error("result queue overflow");

    a_idle_disarmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.press_state == bpc_pkg::StIdle) |-> !r_state.timer_armed)
        else $error("timer armed while press machine idle");

    a_toggle_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.toggle_count < bpc_pkg::TogglesForReset)
        else $error("toggle count not cleared after reset gesture");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ch.valid && i_in_ch.ready) |=> $stable(r_state))
        else $error("classifier state moved without a request");
`endif

endmodule
`default_nettype wire

/* tb/testbench.sv */
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CyclesLimit = 200_000;
    localparam int unsigned DrainCycles = 8;
    localparam int unsigned LongHoldCycles = 300;
    localparam int unsigned RandomPhases = 8;
    localparam int unsigned ItemsPerPhase = 52;
    localparam int unsigned MaxReports = 10;

    typedef logic [bpc_pkg::TimeW-1:0]    t_time;
    typedef logic [bpc_pkg::UptimeW-1:0]  t_uptime;
    typedef logic [bpc_pkg::CfgIdxW-1:0]  t_cfg_idx;
    typedef logic [bpc_pkg::CfgDataW-1:0] t_cfg_data;

    typedef struct packed {
        logic func;
        logic pin_level;
    } t_button_req;

    logic      i_clk;
    logic      i_rst_n;
    logic      cfg_we;
    t_cfg_idx  cfg_idx;
    t_cfg_data cfg_data;

    bpc_in_if  in_ch ();
    bpc_out_if out_ch ();

    button_press_classifier_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // register copy used by the classifier prediction
    logic  set_on_level;
    logic  set_invert;
    logic  set_reset_detect;
    t_time set_short_ms;
    t_time set_long_ms;

    // predicted classifier state
    logic       m_prev;
    logic [2:0] m_state;
    t_time      m_timer;
    logic       m_armed;
    logic [1:0] m_expiries;
    t_uptime    m_uptime;
    t_uptime    m_last_change;
    logic [3:0] m_toggles;

    bpc_pkg::t_result run_events[$];
    bpc_pkg::t_result expected_events[$];
    t_button_req      pending_requests[$];

    logic gen_level;
    logic tx_no_gaps;
    logic rx_no_stall;
    int   tx_gap;
    int   rx_gap;
    int   rx_hold_left;
    int   hold_requests;
    int   holds_started;
    int   req_issued;
    int   req_accepted;
    int   queued_total;
    int   results_taken;
    int   results_seen;
    int   mismatches;
    int   writes_done;
    int   cycle_count;
    int   event_tally[5];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic pin_of(input logic lv);
        return ~(set_on_level ^ lv ^ set_invert);
    endfunction

    task automatic add_event(input logic [2:0] code, input logic lv);
        if (run_events.size() < bpc_pkg::MaxResults)
            run_events.push_back('{event_code: code, logical_level: lv, last_of_run: 1'b0});
    endtask

    task automatic arm_timer(input t_time ms);
        m_timer = (ms == '0) ? t_time'(1) : ms;
        m_armed = 1'b1;
    endtask

    task automatic predict_request(input t_button_req req);
        logic             cur;
        logic             last;
        bpc_pkg::t_result r;
        cur = ((req.pin_level == set_on_level) ? 1'b1 : 1'b0) ^ set_invert;
        run_events.delete();
        if (req.func == bpc_pkg::FuncTick) begin
            if (m_uptime < bpc_pkg::UptimeLimitMs) m_uptime++;
            if (m_armed) begin
                if (m_timer > 0) m_timer--;
                if (m_timer == 0) begin
                    m_armed = 1'b0;
                    if (m_expiries < 2'd3) m_expiries++;
                    m_prev = cur;
                    case (m_state)
                        bpc_pkg::StWaitOffSingle, bpc_pkg::StWaitOffDouble: begin
                            if (set_long_ms > set_short_ms)
                                arm_timer(set_long_ms - set_short_ms);
                            else arm_timer(t_time'(1));
                            m_state = bpc_pkg::StWaitOffLong;
                        end
                        bpc_pkg::StWaitOnDouble: begin
                            add_event(bpc_pkg::EvSingle, cur);
                            m_state = bpc_pkg::StIdle;
                        end
                        bpc_pkg::StWaitOffLong: begin
                            if (m_expiries == 2'd2) add_event(bpc_pkg::EvLong, cur);
                        end
                        default: m_state = bpc_pkg::StIdle;
                    endcase
                end
            end
        end else begin
            last = m_prev;
            m_prev = cur;
            if (cur != last) begin
                add_event(bpc_pkg::EvChange, cur);
                if (set_reset_detect && m_uptime < bpc_pkg::UptimeLimitMs) begin
                    if (m_uptime - m_last_change > bpc_pkg::GapLimitMs) m_toggles = '0;
                    m_toggles++;
                    if (m_toggles >= bpc_pkg::TogglesForReset) begin
                        m_toggles = '0;
                        add_event(bpc_pkg::EvReset, cur);
                    end
                end
                case (m_state)
                    bpc_pkg::StWaitOffSingle: begin
                        if (!cur) m_state = bpc_pkg::StWaitOnDouble;
                    end
                    bpc_pkg::StWaitOnDouble: begin
                        if (cur) begin
                            arm_timer(set_short_ms);
                            m_state = bpc_pkg::StWaitOffDouble;
                            m_expiries = '0;
                        end
                    end
                    bpc_pkg::StWaitOffDouble: begin
                        if (!cur) begin
                            m_armed = 1'b0;
                            m_timer = '0;
                            add_event(bpc_pkg::EvDouble, cur);
                            m_state = bpc_pkg::StIdle;
                        end
                    end
                    bpc_pkg::StWaitOffLong: begin
                        if (!cur) begin
                            m_armed = 1'b0;
                            m_timer = '0;
                            if (m_expiries == 2'd1) add_event(bpc_pkg::EvSingle, cur);
                            m_state = bpc_pkg::StIdle;
                        end
                    end
                    default: begin
                        m_state = bpc_pkg::StIdle;
                        if (cur) begin
                            arm_timer(set_short_ms);
                            m_state = bpc_pkg::StWaitOffSingle;
                            m_expiries = '0;
                        end
                    end
                endcase
                m_last_change = m_uptime;
            end
        end
        for (int i = 0; i < run_events.size(); i++) begin
            r = run_events[i];
            r.last_of_run = (i == run_events.size() - 1);
            expected_events.push_back(r);
        end
    endtask

    task automatic queue_req(input logic kind, input logic pin);
        pending_requests.push_back('{func: kind, pin_level: pin});
        queued_total++;
    endtask

    task automatic queue_change(input logic lv);
        gen_level = lv;
        queue_req(bpc_pkg::FuncPinChange, pin_of(lv));
    endtask

    // ticks carry the held level, now and then a glitched one
    task automatic queue_ticks(input int n, input bit noisy);
        logic pin;
        for (int i = 0; i < n; i++) begin
            pin = pin_of(gen_level);
            if (noisy && $urandom_range(0, 9) == 0) pin = ~pin;
            queue_req(bpc_pkg::FuncTick, pin);
        end
    endtask

    task automatic write_register(input t_cfg_idx idx, input t_cfg_data data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            bpc_pkg::CfgOnLevel:           set_on_level = data[0];
            bpc_pkg::CfgInvertState:       set_invert = data[0];
            bpc_pkg::CfgResetDetectEnable: set_reset_detect = data[0];
            bpc_pkg::CfgShortPressMs:      set_short_ms = data;
            bpc_pkg::CfgLongPressMs:       set_long_ms = data;
            default: ;
        endcase
        writes_done++;
    endtask

    task automatic wait_for_drain();
        while (pending_requests.size() != 0 || req_issued != req_accepted ||
               expected_events.size() != 0)
            @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CyclesLimit) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, expected_events.size());
            $display("Verification failed");
            $finish;
        end
    end

    // request driver
    always @(negedge i_clk) begin : drive_requests
        t_button_req next_req;
        if (req_issued != req_accepted) begin
            // hold the request until it is taken
        end else if (tx_gap > 0) begin
            in_ch.valid <= 1'b0;
            tx_gap--;
        end else if (pending_requests.size() > 0) begin
            next_req = pending_requests.pop_front();
            in_ch.valid     <= 1'b1;
            in_ch.func      <= next_req.func;
            in_ch.pin_level <= next_req.pin_level;
            req_issued++;
            tx_gap = tx_no_gaps ? 0 : $urandom_range(0, 4);
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // result ready, with per-result stalls and the long hold-off
    always @(negedge i_clk) begin
        if (hold_requests != holds_started) begin
            holds_started = hold_requests;
            rx_hold_left = LongHoldCycles;
        end
        if (results_seen != results_taken) begin
            results_seen = results_taken;
            rx_gap = rx_no_stall ? 0 : $urandom_range(0, 4);
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            out_ch.ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : watch_ports
        bpc_pkg::t_result got;
        bpc_pkg::t_result want;
        t_button_req      req;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{event_code: out_ch.event_code, logical_level: out_ch.logical_level,
                        last_of_run: out_ch.last_of_run};
                results_taken++;
                if (got.event_code <= bpc_pkg::EvLong) event_tally[got.event_code]++;
                if (expected_events.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MaxReports)
                        $display("result %0d unexpected: code %0d level %0b last %0b",
                                 results_taken, got.event_code, got.logical_level,
                                 got.last_of_run);
                end else begin
                    want = expected_events.pop_front();
                    if (got.event_code !== want.event_code ||
                        got.logical_level !== want.logical_level ||
                        got.last_of_run !== want.last_of_run) begin
                        mismatches++;
                        if (mismatches <= MaxReports)
                            $display({"result %0d: expected code %0d level %0b last %0b,",
                                      " got code %0d level %0b last %0b"},
                                     results_taken, want.event_code, want.logical_level,
                                     want.last_of_run, got.event_code, got.logical_level,
                                     got.last_of_run);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                req = '{func: in_ch.func, pin_level: in_ch.pin_level};
                predict_request(req);
                req_accepted++;
            end
        end
    end

    initial begin : stimulus
        int start_count;
        int pick;
        int n;
        int t_short;
        int t_long;
        int new_short;
        int new_long;

        in_ch.valid     = 1'b0;
        in_ch.func      = 1'b0;
        in_ch.pin_level = 1'b0;
        out_ch.ready    = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = '0;
        cfg_data        = '0;
        i_rst_n         = 1'b0;

        set_on_level     = 1'b1;
        set_invert       = 1'b0;
        set_reset_detect = 1'b0;
        set_short_ms     = bpc_pkg::ShortPressReset;
        set_long_ms      = bpc_pkg::LongPressReset;
        m_prev           = 1'b0;
        m_state          = bpc_pkg::StIdle;
        m_timer          = '0;
        m_armed          = 1'b0;
        m_expiries       = '0;
        m_uptime         = '0;
        m_last_change    = '0;
        m_toggles        = '0;
        gen_level        = 1'b0;
        tx_no_gaps       = 1'b0;
        rx_no_stall      = 1'b0;
        event_tally      = '{default: 0};

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // power-on timings: idle tick, noise notice, then a double click
        queue_req(bpc_pkg::FuncTick, 1'b1);
        queue_req(bpc_pkg::FuncPinChange, pin_of(1'b0));
        queue_change(1'b1);
        queue_change(1'b0);
        queue_change(1'b1);
        queue_change(1'b0);
        wait_for_drain();

        // zero short time and long not above short: both phases armed with one tick
        write_register(bpc_pkg::CfgShortPressMs, '0);
        write_register(bpc_pkg::CfgLongPressMs, '0);
        queue_change(1'b1);
        queue_ticks(2, 1'b0);
        queue_change(1'b0);
        wait_for_drain();

        // release after the first expiry gives a single
        write_register(bpc_pkg::CfgLongPressMs, t_cfg_data'(3));
        queue_change(1'b1);
        queue_ticks(1, 1'b0);
        queue_change(1'b0);
        wait_for_drain();

        // ten quick toggles: the last one carries change and reset
        write_register(bpc_pkg::CfgResetDetectEnable, t_cfg_data'(1));
        repeat (10) queue_change(~gen_level);
        wait_for_drain();

        // indexes past the register file are ignored
        write_register(t_cfg_idx'(5), t_cfg_data'($urandom));
        write_register(t_cfg_idx'(6), t_cfg_data'($urandom));
        write_register(t_cfg_idx'(7), t_cfg_data'($urandom));

        for (int phase = 0; phase < RandomPhases; phase++) begin
            wait_for_drain();
            tx_no_gaps  = (phase == 1) || ($urandom_range(0, 3) == 0);
            rx_no_stall = (phase == 1) || ($urandom_range(0, 3) == 0);
            if (phase == 2) begin
                tx_no_gaps  = 1'b0;
                rx_no_stall = 1'b0;
            end
            if (phase == 0) begin
                write_register(bpc_pkg::CfgOnLevel, t_cfg_data'(0));
                write_register(bpc_pkg::CfgInvertState, t_cfg_data'(1));
                write_register(bpc_pkg::CfgResetDetectEnable, t_cfg_data'(1));
                write_register(bpc_pkg::CfgShortPressMs, t_cfg_data'(1));
                write_register(bpc_pkg::CfgLongPressMs, t_cfg_data'(2));
            end else if (phase == RandomPhases - 1) begin
                write_register(bpc_pkg::CfgOnLevel, t_cfg_data'(1));
                write_register(bpc_pkg::CfgInvertState, t_cfg_data'(0));
                write_register(bpc_pkg::CfgResetDetectEnable, t_cfg_data'(0));
                write_register(bpc_pkg::CfgShortPressMs, '1);
                write_register(bpc_pkg::CfgLongPressMs, '1);
            end else begin
                pick = $urandom_range(0, 9);
                if (pick == 0) new_short = 0;
                else if (pick == 1) new_short = $urandom_range(0, 65535);
                else new_short = $urandom_range(1, 6);
                pick = $urandom_range(0, 9);
                if (pick < 2) new_long = $urandom_range(0, new_short);
                else if (pick == 2) new_long = 65535;
                else new_long = new_short + $urandom_range(1, 8);
                if (new_long > 65535) new_long = 65535;
                write_register(bpc_pkg::CfgOnLevel, t_cfg_data'($urandom_range(0, 1)));
                write_register(bpc_pkg::CfgInvertState, t_cfg_data'($urandom_range(0, 1)));
                write_register(bpc_pkg::CfgResetDetectEnable,
                               t_cfg_data'($urandom_range(0, 1)));
                write_register(bpc_pkg::CfgShortPressMs, t_cfg_data'(new_short));
                write_register(bpc_pkg::CfgLongPressMs, t_cfg_data'(new_long));
            end
            if (phase == 3) begin
                // receiver holds off while a run of toggles backs up the block
                hold_requests++;
                repeat (24) queue_change(~gen_level);
            end
            t_short = (set_short_ms > 10) ? 10 : set_short_ms;
            t_long  = (set_long_ms > 16) ? 16 : set_long_ms;
            start_count = queued_total;
            while (queued_total - start_count < ItemsPerPhase) begin
                pick = $urandom_range(0, 9);
                case (pick)
                    0, 1, 2: begin
                        queue_change(1'b1);
                        queue_ticks($urandom_range(0, t_short), 1'b1);
                        queue_change(1'b0);
                        queue_ticks($urandom_range(0, t_short + 2), 1'b1);
                    end
                    3, 4: begin
                        queue_change(1'b1);
                        queue_ticks($urandom_range(0, t_short), 1'b1);
                        queue_change(1'b0);
                        queue_ticks($urandom_range(0, t_short), 1'b1);
                        queue_change(1'b1);
                        queue_ticks($urandom_range(0, t_short), 1'b1);
                        queue_change(1'b0);
                        queue_ticks($urandom_range(0, t_short + 2), 1'b1);
                    end
                    5, 6: begin
                        queue_change(1'b1);
                        queue_ticks($urandom_range(t_long, t_long + 3), 1'b1);
                        queue_change(1'b0);
                        queue_ticks($urandom_range(0, 2), 1'b1);
                    end
                    7: begin
                        n = $urandom_range(9, 12);
                        repeat (n) begin
                            queue_change(~gen_level);
                            queue_ticks($urandom_range(0, 2), 1'b1);
                        end
                    end
                    default: begin
                        n = $urandom_range(1, 6);
                        repeat (n) queue_req(1'($urandom_range(0, 1)),
                                             1'($urandom_range(0, 1)));
                    end
                endcase
            end
        end

        // reset gesture run with short timings while the receiver stalls
        wait_for_drain();
        tx_no_gaps  = 1'b1;
        rx_no_stall = 1'b0;
        write_register(bpc_pkg::CfgResetDetectEnable, t_cfg_data'(1));
        write_register(bpc_pkg::CfgShortPressMs, t_cfg_data'(4));
        write_register(bpc_pkg::CfgLongPressMs, t_cfg_data'(8));
        repeat (12) queue_change(~gen_level);
        queue_ticks(20, 1'b0);

        wait_for_drain();
        repeat (DrainCycles) @(negedge i_clk);
        $display("%0d requests through, %0d register writes, %0d results checked",
                 req_accepted, writes_done, results_taken);
        $display("events: change %0d reset %0d single %0d double %0d long %0d",
                 event_tally[bpc_pkg::EvChange], event_tally[bpc_pkg::EvReset],
                 event_tally[bpc_pkg::EvSingle], event_tally[bpc_pkg::EvDouble],
                 event_tally[bpc_pkg::EvLong]);
        if (mismatches == 0 && expected_events.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     mismatches, expected_events.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
